// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file gcb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define GCB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define GCB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define GCB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gcb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants of the grapheme cluster breaker.
// ---------------------------------------------------------------------------
package gcb_pkg;

  // Width of the open-cluster byte counter; it saturates at all ones.
  localparam int LENGTH_BITS  = 16;
  localparam int CLUSTER_BITS = 16;
  localparam int CLASS_BITS   = 5;
  localparam int BYTES_BITS   = 3;

  // Grapheme-break classes as delivered by the lookup upstream.
  typedef enum logic [CLASS_BITS-1:0] {
    CL_OTHER     = 5'd0,
    CL_CR        = 5'd1,
    CL_LF        = 5'd2,
    CL_CONTROL   = 5'd3,
    CL_EXTEND    = 5'd4,
    CL_INCB_EXT  = 5'd5,
    CL_INCB_LINK = 5'd6,
    CL_ZWJ       = 5'd7,
    CL_SPACING   = 5'd8,
    CL_PREPEND   = 5'd9,
    CL_L         = 5'd10,
    CL_V         = 5'd11,
    CL_T         = 5'd12,
    CL_LV        = 5'd13,
    CL_LVT       = 5'd14,
    CL_RI        = 5'd15,
    CL_PICT      = 5'd16,
    CL_CONS      = 5'd17
  } class_t;

  // Scanner position within the open cluster, one-hot.
  typedef enum logic [12:0] {
    S_START    = 13'b0000000000001,
    S_CR       = 13'b0000000000010,
    S_CTRL     = 13'b0000000000100,
    S_L        = 13'b0000000001000,
    S_V        = 13'b0000000010000,
    S_T        = 13'b0000000100000,
    S_PREPEND  = 13'b0000001000000,
    S_CONS     = 13'b0000010000000,
    S_LINK     = 13'b0000100000000,
    S_PICT     = 13'b0001000000000,
    S_PICT_ZWJ = 13'b0010000000000,
    S_RI       = 13'b0100000000000,
    S_MAYBE    = 13'b1000000000000
  } state_t;

  // Outcome of one item: new scanner state and the result it produces.
  typedef struct packed {
    state_t                  next_state;
    logic [LENGTH_BITS-1:0]  next_bytes;
    logic                    done;
    logic [CLUSTER_BITS-1:0] bytes;
  } step_t;

endpackage

// ===== rtl/gcb_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcb_in_if
// Code point channel: break class, UTF-8 length and end-of-text mark.
// ---------------------------------------------------------------------------
interface gcb_in_if;
  logic                            valid;
  logic                            ready;
  logic [gcb_pkg::CLASS_BITS-1:0]  break_class;
  logic [gcb_pkg::BYTES_BITS-1:0]  char_bytes;
  logic                            end_of_text;

  modport source (output valid, output break_class, output char_bytes,
                  output end_of_text, input ready);
  modport sink   (input valid, input break_class, input char_bytes,
                  input end_of_text, output ready);
endinterface

// ===== rtl/gcb_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcb_out_if
// Result channel: cluster boundary flag and finished cluster length.
// ---------------------------------------------------------------------------
interface gcb_out_if;
  logic                              valid;
  logic                              ready;
  logic                              cluster_done;
  logic [gcb_pkg::CLUSTER_BITS-1:0]  cluster_bytes;

  modport source (output valid, output cluster_done, output cluster_bytes,
                  input ready);
  modport sink   (input valid, input cluster_done, input cluster_bytes,
                  output ready);
endinterface

// ===== rtl/gcb_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcb_step
// Boundary rules for one code point: next scanner state, cluster length.
// ---------------------------------------------------------------------------
module gcb_step (
  input  gcb_pkg::state_t                     state,
  input  logic [gcb_pkg::LENGTH_BITS-1:0]     open_bytes,
  input  logic [gcb_pkg::CLASS_BITS-1:0]      break_class,
  input  logic [gcb_pkg::BYTES_BITS-1:0]      char_bytes,
  input  logic                                end_of_text,
  output gcb_pkg::step_t                      step
);

  localparam int LB = gcb_pkg::LENGTH_BITS;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  typedef struct packed {
    logic            brk;
    gcb_pkg::state_t st;
  } join_t;

  // State taken by a code point that opens a cluster
  function automatic gcb_pkg::state_t begin_state(gcb_pkg::class_t c);
    gcb_pkg::state_t s;
    unique case (c)
      gcb_pkg::CL_CR:                       s = gcb_pkg::S_CR;
      gcb_pkg::CL_LF, gcb_pkg::CL_CONTROL:  s = gcb_pkg::S_CTRL;
      gcb_pkg::CL_L:                        s = gcb_pkg::S_L;
      gcb_pkg::CL_V, gcb_pkg::CL_LV:        s = gcb_pkg::S_V;
      gcb_pkg::CL_T, gcb_pkg::CL_LVT:       s = gcb_pkg::S_T;
      gcb_pkg::CL_PREPEND:                  s = gcb_pkg::S_PREPEND;
      gcb_pkg::CL_CONS:                     s = gcb_pkg::S_CONS;
      gcb_pkg::CL_PICT:                     s = gcb_pkg::S_PICT;
      gcb_pkg::CL_RI:                       s = gcb_pkg::S_RI;
      default:                              s = gcb_pkg::S_MAYBE;
    endcase
    return s;
  endfunction

  // Extend, ZWJ and spacing marks join anything (GB9, GB9a)
  function automatic join_t maybe_join(gcb_pkg::class_t c);
    join_t j;
    j.st  = gcb_pkg::S_MAYBE;
    j.brk = !(c >= gcb_pkg::CL_EXTEND && c <= gcb_pkg::CL_SPACING);
    return j;
  endfunction

  function automatic join_t keep(gcb_pkg::state_t s);
    join_t j;
    j.brk = 1'b0;
    j.st  = s;
    return j;
  endfunction

  // Continuation rules per scanner state
  function automatic join_t join_rule(gcb_pkg::state_t s, gcb_pkg::class_t c);
    join_t j;
    j = maybe_join(c);
    unique case (s)
      gcb_pkg::S_CR: begin
        j.brk = (c != gcb_pkg::CL_LF);
        j.st  = gcb_pkg::S_CTRL;
      end
      gcb_pkg::S_CTRL: j.brk = 1'b1;
      gcb_pkg::S_L: begin
        if (c == gcb_pkg::CL_L) j = keep(gcb_pkg::S_L);
        else if (c == gcb_pkg::CL_V || c == gcb_pkg::CL_LV) j = keep(gcb_pkg::S_V);
        else if (c == gcb_pkg::CL_LVT) j = keep(gcb_pkg::S_T);
      end
      gcb_pkg::S_V: begin
        if (c == gcb_pkg::CL_V) j = keep(gcb_pkg::S_V);
        else if (c == gcb_pkg::CL_T) j = keep(gcb_pkg::S_T);
      end
      gcb_pkg::S_T: begin
        if (c == gcb_pkg::CL_T) j = keep(gcb_pkg::S_T);
      end
      gcb_pkg::S_PREPEND: begin
        // Prepend binds forward unless a control follows
        j.brk = (c == gcb_pkg::CL_CR || c == gcb_pkg::CL_LF || c == gcb_pkg::CL_CONTROL);
        j.st  = begin_state(c);
      end
      gcb_pkg::S_CONS: begin
        if (c == gcb_pkg::CL_INCB_EXT || c == gcb_pkg::CL_ZWJ) j = keep(gcb_pkg::S_CONS);
        else if (c == gcb_pkg::CL_INCB_LINK) j = keep(gcb_pkg::S_LINK);
      end
      gcb_pkg::S_LINK: begin
        if (c == gcb_pkg::CL_INCB_EXT || c == gcb_pkg::CL_INCB_LINK ||
            c == gcb_pkg::CL_ZWJ) j = keep(gcb_pkg::S_LINK);
        else if (c == gcb_pkg::CL_CONS) j = keep(gcb_pkg::S_CONS);
      end
      gcb_pkg::S_PICT: begin
        if (c == gcb_pkg::CL_EXTEND || c == gcb_pkg::CL_INCB_EXT ||
            c == gcb_pkg::CL_INCB_LINK) j = keep(gcb_pkg::S_PICT);
        else if (c == gcb_pkg::CL_ZWJ) j = keep(gcb_pkg::S_PICT_ZWJ);
      end
      gcb_pkg::S_PICT_ZWJ: begin
        if (c == gcb_pkg::CL_PICT) j = keep(gcb_pkg::S_PICT);
      end
      gcb_pkg::S_RI: begin
        if (c == gcb_pkg::CL_RI) j = keep(gcb_pkg::S_MAYBE);
      end
      default: ;
    endcase
    return j;
  endfunction

  // Saturating length add
  function automatic logic [LB-1:0] add_sat(logic [LB-1:0] a,
                                            logic [gcb_pkg::BYTES_BITS-1:0] b);
    logic [LB:0] sum;
    sum = {1'b0, a} + (LB+1)'(b);
    return (sum >= {1'b0, LEN_MAX}) ? LEN_MAX : sum[LB-1:0];
  endfunction

  gcb_pkg::class_t cls;
  join_t           jr;
  logic            is_open;

  // Classes past the last defined one behave as Other
  assign cls = (break_class > gcb_pkg::CL_CONS) ? gcb_pkg::CL_OTHER
                                                : gcb_pkg::class_t'(break_class);
  assign jr      = join_rule(state, cls);
  assign is_open = (state != gcb_pkg::S_START);

  always_comb begin
    step.done       = 1'b0;
    step.bytes      = '0;
    step.next_state = begin_state(cls);
    step.next_bytes = add_sat('0, char_bytes);
    priority if (end_of_text) begin
      step.done       = is_open;
      step.bytes      = is_open ? gcb_pkg::CLUSTER_BITS'(open_bytes) : '0;
      step.next_state = gcb_pkg::S_START;
      step.next_bytes = '0;
    end else if (!is_open) begin
      // first code point of the text: defaults apply
    end else if (jr.brk) begin
      step.done  = 1'b1;
      step.bytes = gcb_pkg::CLUSTER_BITS'(open_bytes);
    end else begin
      step.next_state = jr.st;
      step.next_bytes = add_sat(open_bytes, char_bytes);
    end
  end

endmodule

// ===== rtl/grapheme_cluster_breaker_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grapheme_cluster_breaker_unit
// Streaming extended grapheme cluster boundary detector with cluster length.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  items     in         break_class, char_bytes, end_of_text
//  results   out        cluster_done, cluster_bytes
//
//  One item per cycle unless results stalls; each item passes the input register
//  and then the result register. The rule-state and byte-count update is the only
//  loop. Synchronous reset returns to start of text with no cluster open.
//  A stalled result holds in the output register; one further item waits
//  in the input register, after which items is held off.
module grapheme_cluster_breaker_unit (
  input logic       clk,
  input logic       rst,
  gcb_in_if.sink    items,
  gcb_out_if.source results
);

  // Input register
  logic                            v1;
  logic [gcb_pkg::CLASS_BITS-1:0]  cls1;
  logic [gcb_pkg::BYTES_BITS-1:0]  nb1;
  logic                            eot1;

  // Scanner state
  gcb_pkg::state_t                  rule_state;
  logic [gcb_pkg::LENGTH_BITS-1:0]  open_bytes;

  // Result register
  logic                             ov;
  logic                             done_r;
  logic [gcb_pkg::CLUSTER_BITS-1:0] bytes_r;

  gcb_pkg::step_t step;
  logic           adv;

  assign adv         = !ov || results.ready;
  assign items.ready = !v1 || adv;

  gcb_step u_step (
    .state       (rule_state),
    .open_bytes  (open_bytes),
    .break_class (cls1),
    .char_bytes  (nb1),
    .end_of_text (eot1),
    .step        (step)
  );

  // Control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      ov         <= 1'b0;
      rule_state <= gcb_pkg::S_START;
      open_bytes <= '0;
    end else begin
      if (items.valid && items.ready) v1 <= 1'b1;
      else if (adv)                   v1 <= 1'b0;

      if (v1 && adv) begin
        ov         <= 1'b1;
        rule_state <= step.next_state;
        open_bytes <= step.next_bytes;
      end else if (results.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      cls1 <= items.break_class;
      nb1  <= items.char_bytes;
      eot1 <= items.end_of_text;
    end
    if (v1 && adv) begin
      done_r  <= step.done;
      bytes_r <= step.bytes;
    end
  end

  assign results.valid         = ov;
  assign results.cluster_done  = done_r;
  assign results.cluster_bytes = bytes_r;

endmodule

// ===== rtl/gcb_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcb_checker
// Port-level checks on the breaker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_done,
  input logic [gcb_pkg::CLUSTER_BITS-1:0]  out_bytes
);

  // Reset empties the result register
  `GCB_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result valid after reset")

  // A result without a boundary carries no length
  `GCB_ASSERT_NOW(a_no_done_zero, clk, rst, out_valid && !out_done, out_bytes == '0, "length without boundary")

  // Stalled transfer keeps valid
  `GCB_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Stalled transfer keeps its payload
  `GCB_ASSERT_NEXT(a_hold_data, clk, rst, out_valid && !out_ready, $stable(out_done) && $stable(out_bytes), "result changed while stalled")

endmodule

bind grapheme_cluster_breaker_unit gcb_checker u_gcb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_done  (results.cluster_done),
  .out_bytes (results.cluster_bytes)
);

// ===== bench/grapheme_cluster_breaker_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grapheme_cluster_breaker_unit_tb
// Self-checking bench for the streaming grapheme cluster breaker. A table of
// directed code points opens the run. Random well-formed clusters (Hangul,
// emoji ZWJ chains, InCB conjuncts, RI pairs, CR LF, prepends, marks) follow,
// mixed with noise and text ends. Every result transfer is checked against
// an in-bench scanner model (typed script rows: the row's own expectation),
// under several source and sink idling patterns. The run includes a long sink
// hold-off and one long cluster of wide marks.
module grapheme_cluster_breaker_unit_tb;

  localparam int QUIET_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 300;    // long sink hold-off
  localparam int LONG_RUN    = 24;     // 7-byte marks in the long cluster
  localparam int PHASE_ITEMS = 220;    // items per random phase

  typedef struct packed {
    logic [gcb_pkg::CLASS_BITS-1:0]   cls;
    logic [gcb_pkg::BYTES_BITS-1:0]   nb;
    logic                             eot;
    logic                             typed;    // expected result given in the row
    logic                             done;
    logic [gcb_pkg::CLUSTER_BITS-1:0] bytes;
  } cp_row_t;

  typedef struct packed {
    logic                             done;
    logic [gcb_pkg::CLUSTER_BITS-1:0] bytes;
  } boundary_t;

  logic clk;
  logic rst;

  gcb_in_if  in_ch ();
  gcb_out_if out_ch ();

  grapheme_cluster_breaker_unit uut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  // Scanner model state
  gcb_pkg::state_t                 scan_state;
  logic [gcb_pkg::LENGTH_BITS-1:0] scan_bytes;

  boundary_t   pending_clusters[$];
  int unsigned mismatches;
  int unsigned sent;
  int unsigned quiet;
  int unsigned src_idle;
  int unsigned sink_stall;
  int unsigned hold_left;
  logic        hold_req;

  gcb_pkg::class_t jamo_set  [5] = '{gcb_pkg::CL_L, gcb_pkg::CL_V, gcb_pkg::CL_T,
                                     gcb_pkg::CL_LV, gcb_pkg::CL_LVT};
  gcb_pkg::class_t pict_ext  [3] = '{gcb_pkg::CL_EXTEND, gcb_pkg::CL_INCB_EXT,
                                     gcb_pkg::CL_INCB_LINK};
  gcb_pkg::class_t conj_join [3] = '{gcb_pkg::CL_INCB_EXT, gcb_pkg::CL_ZWJ,
                                     gcb_pkg::CL_INCB_LINK};
  gcb_pkg::class_t ctrl_set  [3] = '{gcb_pkg::CL_CR, gcb_pkg::CL_LF,
                                     gcb_pkg::CL_CONTROL};

  // Directed script; typed rows carry an expectation read straight off the rules
  cp_row_t script [27] = '{
    '{5'd31,                 3'd7, 1'b1, 1'b1, 1'b0, 16'd0},  // text end, nothing open
    '{gcb_pkg::CL_OTHER,     3'd1, 1'b0, 1'b1, 1'b0, 16'd0},
    '{gcb_pkg::CL_EXTEND,    3'd4, 1'b0, 1'b1, 1'b0, 16'd0},
    '{gcb_pkg::CL_CR,        3'd2, 1'b0, 1'b1, 1'b1, 16'd5},
    '{gcb_pkg::CL_LF,        3'd1, 1'b0, 1'b1, 1'b0, 16'd0},
    '{gcb_pkg::CL_CONTROL,   3'd3, 1'b0, 1'b1, 1'b1, 16'd3},
    '{gcb_pkg::CL_L,         3'd3, 1'b0, 1'b1, 1'b1, 16'd3},
    '{gcb_pkg::CL_V,         3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_T,         3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_LV,        3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_LVT,       3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_PREPEND,   3'd2, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_CONS,      3'd5, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_INCB_EXT,  3'd6, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_INCB_LINK, 3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_ZWJ,       3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_CONS,      3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_SPACING,   3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_PICT,      3'd4, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_ZWJ,       3'd3, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_PICT,      3'd4, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_RI,        3'd4, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_RI,        3'd4, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_RI,        3'd4, 1'b0, 1'b0, 1'b0, 16'd0},
    '{5'd31,                 3'd0, 1'b0, 1'b0, 1'b0, 16'd0},  // unknown class, zero bytes
    '{5'd18,                 3'd7, 1'b0, 1'b0, 1'b0, 16'd0},
    '{gcb_pkg::CL_CONS,      3'd5, 1'b1, 1'b0, 1'b0, 16'd0}   // text end, fields ignored
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Scanner model
  // ------------------------------------------------------------------

  // State taken by a code point that opens a cluster
  function automatic gcb_pkg::state_t opening_state(gcb_pkg::class_t c);
    case (c)
      gcb_pkg::CL_CR:                       return gcb_pkg::S_CR;
      gcb_pkg::CL_LF, gcb_pkg::CL_CONTROL:  return gcb_pkg::S_CTRL;
      gcb_pkg::CL_L:                        return gcb_pkg::S_L;
      gcb_pkg::CL_V, gcb_pkg::CL_LV:        return gcb_pkg::S_V;
      gcb_pkg::CL_T, gcb_pkg::CL_LVT:       return gcb_pkg::S_T;
      gcb_pkg::CL_PREPEND:                  return gcb_pkg::S_PREPEND;
      gcb_pkg::CL_CONS:                     return gcb_pkg::S_CONS;
      gcb_pkg::CL_PICT:                     return gcb_pkg::S_PICT;
      gcb_pkg::CL_RI:                       return gcb_pkg::S_RI;
      default:                              return gcb_pkg::S_MAYBE;
    endcase
  endfunction

  // Extend, InCB marks, ZWJ and SpacingMark join anything; S_START flags a boundary
  function automatic gcb_pkg::state_t mark_join(gcb_pkg::class_t c);
    return (c >= gcb_pkg::CL_EXTEND && c <= gcb_pkg::CL_SPACING) ? gcb_pkg::S_MAYBE
                                                                 : gcb_pkg::S_START;
  endfunction

  // State after c joins the open cluster, or S_START if a boundary falls before c
  function automatic gcb_pkg::state_t join_state(gcb_pkg::state_t s, gcb_pkg::class_t c);
    case (s)
      gcb_pkg::S_CR:   return (c == gcb_pkg::CL_LF) ? gcb_pkg::S_CTRL : gcb_pkg::S_START;
      gcb_pkg::S_CTRL: return gcb_pkg::S_START;
      gcb_pkg::S_L: begin
        if (c == gcb_pkg::CL_L) return gcb_pkg::S_L;
        if (c == gcb_pkg::CL_V || c == gcb_pkg::CL_LV) return gcb_pkg::S_V;
        if (c == gcb_pkg::CL_LVT) return gcb_pkg::S_T;
        return mark_join(c);
      end
      gcb_pkg::S_V: begin
        if (c == gcb_pkg::CL_V) return gcb_pkg::S_V;
        if (c == gcb_pkg::CL_T) return gcb_pkg::S_T;
        return mark_join(c);
      end
      gcb_pkg::S_T:    return (c == gcb_pkg::CL_T) ? gcb_pkg::S_T : mark_join(c);
      gcb_pkg::S_PREPEND: begin
        if (c == gcb_pkg::CL_CR || c == gcb_pkg::CL_LF || c == gcb_pkg::CL_CONTROL)
          return gcb_pkg::S_START;
        return opening_state(c);
      end
      gcb_pkg::S_CONS: begin
        if (c == gcb_pkg::CL_INCB_EXT || c == gcb_pkg::CL_ZWJ) return gcb_pkg::S_CONS;
        if (c == gcb_pkg::CL_INCB_LINK) return gcb_pkg::S_LINK;
        return mark_join(c);
      end
      gcb_pkg::S_LINK: begin
        if (c == gcb_pkg::CL_INCB_EXT || c == gcb_pkg::CL_INCB_LINK ||
            c == gcb_pkg::CL_ZWJ) return gcb_pkg::S_LINK;
        if (c == gcb_pkg::CL_CONS) return gcb_pkg::S_CONS;
        return mark_join(c);
      end
      gcb_pkg::S_PICT: begin
        if (c == gcb_pkg::CL_EXTEND || c == gcb_pkg::CL_INCB_EXT ||
            c == gcb_pkg::CL_INCB_LINK) return gcb_pkg::S_PICT;
        if (c == gcb_pkg::CL_ZWJ) return gcb_pkg::S_PICT_ZWJ;
        return mark_join(c);
      end
      gcb_pkg::S_PICT_ZWJ: return (c == gcb_pkg::CL_PICT) ? gcb_pkg::S_PICT : mark_join(c);
      gcb_pkg::S_RI:       return (c == gcb_pkg::CL_RI) ? gcb_pkg::S_MAYBE : mark_join(c);
      default:             return mark_join(c);
    endcase
  endfunction

  // Length add, saturating at all ones
  function automatic logic [gcb_pkg::LENGTH_BITS-1:0] sat_add(
      logic [gcb_pkg::LENGTH_BITS-1:0] a, logic [gcb_pkg::BYTES_BITS-1:0] b);
    logic [gcb_pkg::LENGTH_BITS:0] sum;
    sum = {1'b0, a} + (gcb_pkg::LENGTH_BITS+1)'(b);
    return sum[gcb_pkg::LENGTH_BITS] ? {gcb_pkg::LENGTH_BITS{1'b1}}
                                     : sum[gcb_pkg::LENGTH_BITS-1:0];
  endfunction

  // Advance the model by one item and return the boundary it reports
  function automatic boundary_t advance_scanner(logic [gcb_pkg::CLASS_BITS-1:0] raw,
                                                logic [gcb_pkg::BYTES_BITS-1:0] nb,
                                                logic eot);
    boundary_t       b;
    gcb_pkg::class_t c;
    gcb_pkg::state_t nxt;
    b = '0;
    c = (raw > gcb_pkg::CL_CONS) ? gcb_pkg::CL_OTHER : gcb_pkg::class_t'(raw);
    if (eot) begin
      if (scan_state != gcb_pkg::S_START) begin
        b.done  = 1'b1;
        b.bytes = gcb_pkg::CLUSTER_BITS'(scan_bytes);
      end
      scan_state = gcb_pkg::S_START;
      scan_bytes = '0;
    end else if (scan_state == gcb_pkg::S_START) begin
      scan_state = opening_state(c);
      scan_bytes = sat_add('0, nb);
    end else begin
      nxt = join_state(scan_state, c);
      if (nxt == gcb_pkg::S_START) begin
        b.done     = 1'b1;
        b.bytes    = gcb_pkg::CLUSTER_BITS'(scan_bytes);
        scan_state = opening_state(c);
        scan_bytes = sat_add('0, nb);
      end else begin
        scan_state = nxt;
        scan_bytes = sat_add(scan_bytes, nb);
      end
    end
    return b;
  endfunction

  // ------------------------------------------------------------------
  // Source side
  // ------------------------------------------------------------------

  // Offer one item, wait for its transfer, then queue its expected boundary
  task automatic offer(input cp_row_t r);
    boundary_t exp_b;
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.break_class <= r.cls;
    in_ch.char_bytes  <= r.nb;
    in_ch.end_of_text <= r.eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_b = advance_scanner(r.cls, r.nb, r.eot);
    if (r.typed) begin
      exp_b.done  = r.done;
      exp_b.bytes = r.bytes;
    end
    pending_clusters.push_back(exp_b);
    sent++;
  endtask

  // Mostly real UTF-8 lengths, now and then an odd count
  function automatic logic [gcb_pkg::BYTES_BITS-1:0] pick_bytes();
    return ($urandom_range(15) == 0) ? gcb_pkg::BYTES_BITS'($urandom_range(7))
                                     : gcb_pkg::BYTES_BITS'($urandom_range(4, 1));
  endfunction

  task automatic send_cp(input logic [gcb_pkg::CLASS_BITS-1:0] cls);
    offer('{cls, pick_bytes(), 1'b0, 1'b0, 1'b0, 16'd0});
  endtask

  // One random cluster shape, or noise
  task automatic send_cluster();
    int unsigned kind;
    kind = $urandom_range(11);
    case (kind)
      0, 1: begin
        // Hangul jamo runs
        repeat ($urandom_range(5, 1)) send_cp(jamo_set[$urandom_range(4)]);
      end
      2: begin
        // emoji with ZWJ chain
        send_cp(gcb_pkg::CL_PICT);
        repeat ($urandom_range(2)) send_cp(pict_ext[$urandom_range(2)]);
        repeat ($urandom_range(2)) begin
          send_cp(gcb_pkg::CL_ZWJ);
          send_cp(($urandom_range(5) == 0) ? gcb_pkg::CL_OTHER : gcb_pkg::CL_PICT);
        end
      end
      3: begin
        // InCB conjunct
        send_cp(gcb_pkg::CL_CONS);
        repeat ($urandom_range(3, 1)) begin
          repeat ($urandom_range(2)) send_cp(conj_join[$urandom_range(2)]);
          send_cp(gcb_pkg::CL_CONS);
        end
      end
      4:  repeat ($urandom_range(4, 1)) send_cp(gcb_pkg::CL_RI);
      5: begin
        // line ends and controls
        if ($urandom_range(1)) begin
          send_cp(gcb_pkg::CL_CR);
          send_cp(gcb_pkg::CL_LF);
        end else begin
          send_cp(ctrl_set[$urandom_range(2)]);
        end
      end
      6: begin
        repeat ($urandom_range(2, 1)) send_cp(gcb_pkg::CL_PREPEND);
        send_cp(gcb_pkg::CLASS_BITS'($urandom_range(31)));
      end
      7, 8: begin
        // base followed by marks
        send_cp(($urandom_range(1)) ? gcb_pkg::CL_OTHER
                                    : gcb_pkg::CLASS_BITS'($urandom_range(31)));
        repeat ($urandom_range(3))
          send_cp(gcb_pkg::CLASS_BITS'($urandom_range(gcb_pkg::CL_SPACING,
                                                       gcb_pkg::CL_EXTEND)));
      end
      9:  offer('{gcb_pkg::CLASS_BITS'($urandom_range(31)),
                  gcb_pkg::BYTES_BITS'($urandom_range(7)),
                  1'b1, 1'b0, 1'b0, 16'd0});
      default: begin
        repeat ($urandom_range(4, 1))
          offer('{gcb_pkg::CLASS_BITS'($urandom_range(31)),
                  gcb_pkg::BYTES_BITS'($urandom_range(7)),
                  ($urandom_range(7) == 0), 1'b0, 1'b0, 16'd0});
      end
    endcase
  endtask

  // ------------------------------------------------------------------
  // Sink side: random stalls, plus one long hold-off on request
  // ------------------------------------------------------------------
  initial begin
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    boundary_t exp_b;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_clusters.size() == 0) begin
        $display("%0t: unexpected result done=%0b bytes=%0d", $time,
                 out_ch.cluster_done, out_ch.cluster_bytes);
        mismatches++;
      end else begin
        exp_b = pending_clusters.pop_front();
        if (out_ch.cluster_done !== exp_b.done) begin
          $display("%0t: cluster_done expected %0b actual %0b", $time,
                   exp_b.done, out_ch.cluster_done);
          mismatches++;
        end
        if (out_ch.cluster_bytes !== exp_b.bytes) begin
          $display("%0t: cluster_bytes expected %0d actual %0d", $time,
                   exp_b.bytes, out_ch.cluster_bytes);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("grapheme_cluster_breaker_unit_tb NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    int unsigned phase_end;
    mismatches = 0;
    sent       = 0;
    hold_req   = 1'b0;
    src_idle   = 0;
    sink_stall = 0;
    scan_state = gcb_pkg::S_START;
    scan_bytes = '0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.break_class <= '0;
    in_ch.char_bytes  <= '0;
    in_ch.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[i]) offer(script[i]);

    // phase 0: no idling, long sink hold-off, then one long cluster
    hold_req  = 1'b1;
    phase_end = sent + PHASE_ITEMS;
    while (sent < phase_end) send_cluster();
    offer('{gcb_pkg::CL_OTHER, 3'd1, 1'b1, 1'b0, 1'b0, 16'd0});
    send_cp(gcb_pkg::CL_OTHER);
    repeat (LONG_RUN) offer('{gcb_pkg::CL_EXTEND, 3'd7, 1'b0, 1'b0, 1'b0, 16'd0});
    send_cp(gcb_pkg::CL_CONTROL);

    // phase 1: source idle
    src_idle  = 53;
    phase_end = sent + PHASE_ITEMS;
    while (sent < phase_end) send_cluster();

    // phase 2: sink stalls
    src_idle   = 0;
    sink_stall = 53;
    phase_end  = sent + PHASE_ITEMS;
    while (sent < phase_end) send_cluster();

    // phase 3: both sides idle now and then
    src_idle   = 16;
    sink_stall = 16;
    phase_end  = sent + PHASE_ITEMS;
    while (sent < phase_end) send_cluster();
    offer('{gcb_pkg::CL_OTHER, 3'd0, 1'b1, 1'b0, 1'b0, 16'd0});
    in_ch.valid <= 1'b0;

    // drain, then allow for the output latency
    while (pending_clusters.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("grapheme_cluster_breaker_unit_tb OK");
    end else begin
      $display("grapheme_cluster_breaker_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gcb_pkg.sv
rtl/gcb_in_if.sv
rtl/gcb_out_if.sv
rtl/gcb_step.sv
rtl/grapheme_cluster_breaker_unit.sv
rtl/gcb_checker.sv
bench/grapheme_cluster_breaker_unit_tb.sv
